// File: rtl/core/avc2ab_pkg.sv
`timescale 1ns / 1ps

package avc2ab_pkg;

  // Length prefix size in bytes; the start code replaces it byte for byte.
  localparam int unsigned LengthFieldBytes = 4;
  localparam int unsigned LenIdxW = $clog2(LengthFieldBytes);
  localparam logic [LenIdxW-1:0] LenIdxLast = LenIdxW'(LengthFieldBytes - 1);

  localparam int unsigned CountW = 32;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [31:0] CapacityReset = 32'hFFFF_FFFF;

  // APB register map
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned RegIdxW = 1;
  localparam logic [RegIdxW-1:0] RegOutCapacity = 1'b0;

  localparam logic [4:0] NalTypeMask = 5'h1f;
  localparam logic [4:0] NalTypeIdr = 5'd5;
  localparam logic [4:0] NalTypeSps = 5'd7;
  localparam logic [4:0] NalTypePps = 5'd8;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_TOO_SMALL = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_ok;
    logic              last_out;
    status_e           status;
    logic              has_sps;
    logic              has_pps;
    logic              has_idr;
    logic [CountW-1:0] unit_count;
    logic [CountW-1:0] out_length;
  } result_t;

  // Input beat handed from the input register to the converter.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  function automatic logic [7:0] start_code_byte(input logic [LenIdxW-1:0] idx);
    start_code_byte = (idx == LenIdxLast) ? 8'h01 : 8'h00;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == CountMax) ? v : v + CountW'(1);
  endfunction

endpackage

// File: rtl/core/avc2ab_in_reg.sv
`timescale 1ns / 1ps

module avc2ab_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic                 take_i,
  output avc2ab_pkg::in_beat_t beat_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       last_q;
  logic       load;

  // The register refills in the same cycle its beat moves on.
  assign s_axis_tready = !valid_q || take_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.data  = data_q;
  assign beat_o.last  = last_q;

endmodule

// File: rtl/core/avc2ab_cfg.sv
`timescale 1ns / 1ps

module avc2ab_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [avc2ab_pkg::ApbAddrW-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic [31:0]                         out_capacity_o
);

  logic [31:0] capacity_q;
  logic        sel_capacity;

  assign pready = 1'b1;
  assign sel_capacity =
    (paddr[avc2ab_pkg::ApbAddrW-1:2] == avc2ab_pkg::RegOutCapacity);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= avc2ab_pkg::CapacityReset;
    end else if (psel && penable && pwrite && pready && sel_capacity) begin
      capacity_q <= pwdata;
    end
  end

  assign prdata         = sel_capacity ? capacity_q : 32'h0;
  assign out_capacity_o = capacity_q;

endmodule

// File: rtl/core/avc2ab_conv.sv
`timescale 1ns / 1ps

module avc2ab_conv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  avc2ab_pkg::in_beat_t  beat_i,
  output logic                  take_o,
  input  logic [31:0]           out_capacity_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output avc2ab_pkg::result_t   result_o
);

  localparam int unsigned IdxW = avc2ab_pkg::LenIdxW;
  localparam int unsigned CntW = avc2ab_pkg::CountW;
  localparam int unsigned AccW = 8 * (avc2ab_pkg::LengthFieldBytes - 1);

  logic            in_payload_q, in_payload_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [31:0]     rem_q, rem_d;
  logic            hdr_q, hdr_d;
  logic            err_q, err_d;
  logic            sps_q, sps_d, pps_q, pps_d, idr_q, idr_d;
  logic [CntW-1:0] nal_q, nal_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  avc2ab_pkg::result_t res_q, res_d;

  logic [31:0]     len_full;
  logic [4:0]      hdr_type;

  assign take_o   = beat_i.valid && (!out_valid_q || out_ready_i);
  assign len_full = {acc_q, beat_i.data};
  assign hdr_type = beat_i.data[4:0] & avc2ab_pkg::NalTypeMask;

  always_comb begin
    in_payload_d = in_payload_q;
    idx_d        = idx_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    hdr_d        = hdr_q;
    err_d        = err_q;
    sps_d        = sps_q;
    pps_d        = pps_q;
    idr_d        = idr_q;
    nal_d        = nal_q;
    res_d        = res_q;

    if (!in_payload_q) begin
      res_d.out_byte = avc2ab_pkg::start_code_byte(idx_q);
      if (idx_q == avc2ab_pkg::LenIdxLast) begin
        if (len_full == 32'h0) begin
          err_d = 1'b1;
        end else begin
          in_payload_d = 1'b1;
          rem_d        = len_full;
          hdr_d        = 1'b1;
        end
        idx_d = '0;
        acc_d = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
        acc_d = len_full[AccW-1:0];
      end
    end else begin
      res_d.out_byte = beat_i.data;
      // The first payload byte is the NAL header; count the unit there.
      if (hdr_q) begin
        if (!err_q) begin
          priority if (hdr_type == avc2ab_pkg::NalTypeSps) begin
            sps_d = 1'b1;
          end else if (hdr_type == avc2ab_pkg::NalTypePps) begin
            pps_d = 1'b1;
          end else if (hdr_type == avc2ab_pkg::NalTypeIdr) begin
            idr_d = 1'b1;
          end else begin
            sps_d = sps_q;
          end
          nal_d = avc2ab_pkg::sat_inc(nal_q);
        end
        hdr_d = 1'b0;
      end
      rem_d = rem_q - 32'd1;
      if (rem_q == 32'd1) begin
        in_payload_d = 1'b0;
      end
    end

    // A buffer that ends inside a prefix or a payload is truncated.
    if (beat_i.last && (in_payload_d || idx_d != '0)) begin
      err_d = 1'b1;
    end

    cnt_d = err_d ? cnt_q : avc2ab_pkg::sat_inc(cnt_q);

    res_d.status = avc2ab_pkg::STATUS_OK;
    if (beat_i.last) begin
      if (err_d || nal_d == '0) begin
        res_d.status = avc2ab_pkg::STATUS_INVALID;
      end else if (cnt_d > out_capacity_i) begin
        res_d.status = avc2ab_pkg::STATUS_TOO_SMALL;
      end
    end

    res_d.byte_ok    = !err_d;
    res_d.last_out   = beat_i.last;
    res_d.has_sps    = sps_d;
    res_d.has_pps    = pps_d;
    res_d.has_idr    = idr_d;
    res_d.unit_count = nal_d;
    res_d.out_length = cnt_d;

    // The final byte closes the buffer; the next one starts from scratch.
    if (beat_i.last) begin
      in_payload_d = 1'b0;
      idx_d        = '0;
      acc_d        = '0;
      rem_d        = '0;
      hdr_d        = 1'b0;
      err_d        = 1'b0;
      sps_d        = 1'b0;
      pps_d        = 1'b0;
      idr_d        = 1'b0;
      nal_d        = '0;
      cnt_d        = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      idx_q        <= '0;
      acc_q        <= '0;
      rem_q        <= '0;
      hdr_q        <= 1'b0;
      err_q        <= 1'b0;
      sps_q        <= 1'b0;
      pps_q        <= 1'b0;
      idr_q        <= 1'b0;
      nal_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        in_payload_q <= in_payload_d;
        idx_q        <= idx_d;
        acc_q        <= acc_d;
        rem_q        <= rem_d;
        hdr_q        <= hdr_d;
        err_q        <= err_d;
        sps_q        <= sps_d;
        pps_q        <= pps_d;
        idr_q        <= idr_d;
        nal_q        <= nal_d;
        cnt_q        <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// File: rtl/core/avc_to_annexb_converter_unit.sv
`timescale 1ns / 1ps

// Converts an H.264 length-prefixed (AVC) buffer to Annex B, one byte per
// beat in and one beat out: each 4-byte big-endian length prefix leaves as
// the start code 00 00 00 01 and payload bytes pass unchanged. tlast marks
// the final byte of a buffer; that beat carries the status (ok, invalid, or
// output larger than out_capacity), and all per-buffer state then clears.
// Each beat passes through an input register and then a result register,
// and the unit sustains one byte per clock while m_axis_tready stays high.
// tuser is 1 while no format error has been seen in the buffer.
// out_capacity sits at APB address 0; the user must see that it is written
// only while no buffer is in flight, as the block itself does not enforce it.
module avc_to_annexb_converter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [avc2ab_pkg::ApbAddrW-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // in_byte
  input  logic                              s_axis_tlast,  // last_in
  // Output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_byte[7:0], status[9:8], has_sps[10], has_pps[11], has_idr[12],
  // unit_count[44:13], out_length[76:45], zero[79:77]
  output logic [79:0]                       m_axis_tdata,
  output logic                              m_axis_tuser,  // byte_ok
  output logic                              m_axis_tlast   // last_out
);

  avc2ab_pkg::in_beat_t beat;
  avc2ab_pkg::result_t  res;
  logic                 take;
  logic [31:0]          out_capacity;

  avc2ab_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .out_capacity_o (out_capacity)
  );

  avc2ab_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take_i        (take),
    .beat_o        (beat)
  );

  avc2ab_conv u_conv (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .take_o         (take),
    .out_capacity_i (out_capacity),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.out_length, res.unit_count, res.has_idr,
                         res.has_pps, res.has_sps, res.status, res.out_byte};
  assign m_axis_tuser = res.byte_ok;
  assign m_axis_tlast = res.last_out;

endmodule
